@@ rtl/bbrg_pkg.sv @@
package bbrg_pkg;

  localparam int BATCH_W = 8;
  localparam int BYTE_W  = 36;
  localparam int PROD_W  = BYTE_W + BATCH_W;
  localparam int ALU_W   = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_CNT_W = $clog2(BATCH_W);

  localparam logic [CFG_IDX_W-1:0] REG_MIN_BATCH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BATCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_BYTES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_BYTES  = 3'd4;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [BATCH_W-1:0] MIN_BATCH_RST     = 8'd1;
  localparam logic [BATCH_W-1:0] DEFAULT_BATCH_RST = 8'd8;
  localparam logic [BYTE_W-1:0]  ACT_BYTES_RST     = 36'd67108864;
  localparam logic [BYTE_W-1:0]  WEIGHT_BYTES_RST  = 36'd536870912;
  localparam logic [BYTE_W-1:0]  BUDGET_BYTES_RST  = 36'd1610612736;

  typedef logic [BATCH_W-1:0] batch_t;
  typedef logic [BYTE_W-1:0]  bytes_t;
  typedef logic [ALU_W-1:0]   alu_word_t;

  typedef struct packed {
    batch_t min_batch;
    batch_t default_batch;
    bytes_t activation_bytes;
    bytes_t weight_bytes;
    bytes_t budget_bytes;
  } cfg_t;

  function automatic alu_word_t ext_bytes(input bytes_t x);
    ext_bytes = {{(ALU_W-BYTE_W){1'b0}}, x};
  endfunction

endpackage

@@ rtl/bbrg_in_if.sv @@
interface bbrg_in_if;
  import bbrg_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  batch_t batch;

  modport source (output valid, output command, output batch, input ready);
  modport sink   (input valid, input command, input batch, output ready);
endinterface

@@ rtl/bbrg_out_if.sv @@
interface bbrg_out_if;
  import bbrg_pkg::*;

  logic   valid;
  logic   ready;
  batch_t granted;
  logic   success;
  bytes_t occupancy;

  modport source (output valid, output granted, output success, output occupancy,
                  input ready);
  modport sink   (input valid, input granted, input success, input occupancy,
                  output ready);
endinterface

@@ rtl/batch_budget_reservation_guard.sv @@
// channel   | dir | beat fields                       | handshake
// ----------+-----+-----------------------------------+-------------
// in_ch     | in  | command, batch                    | valid/ready
// out_ch    | out | granted, success, occupancy       | valid/ready
// cfg_*     | in  | cfg_idx, cfg_data                 | cfg_we only
//
// One adder/subtractor is time-shared by the sequencer. Acquire: accept,
// shift-add multiply, MAXW/SLACK/QSUM/RINIT setup, search from the clamped
// start down to the minimum batch, update on a grant, output. Release: accept,
// multiply, difference, compare, output; batch 0 or empty clamp skips to output.
// Reset (rst_n low, synchronous) loads register defaults and sets occupancy
// to the default weight bytes. in_ch.ready is high only while idle; a result
// waiting on out_ch does not block the next accept, only the next result.
module batch_budget_reservation_guard (
  input  logic                           clk,
  input  logic                           rst_n,
  bbrg_in_if.sink                        in_ch,
  bbrg_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bbrg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bbrg_pkg::BYTE_W-1:0]    cfg_data
);
  import bbrg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MAXW  = 4'd2;
  localparam logic [3:0] S_SLACK = 4'd3;
  localparam logic [3:0] S_QSUM  = 4'd4;
  localparam logic [3:0] S_RINIT = 4'd5;
  localparam logic [3:0] S_SRCH  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_RDIF  = 4'd8;
  localparam logic [3:0] S_RCMP  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  cfg_t cfg;

  logic [3:0]           state_r, state_nxt;
  logic                 cmd_r, cmd_nxt;
  batch_t               tb_r, tb_nxt;
  batch_t               mc_r, mc_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  alu_word_t            prod_r, prod_nxt;
  alu_word_t            acc_r, acc_nxt;
  alu_word_t            slack_r, slack_nxt;
  alu_word_t            q_r, q_nxt;
  alu_word_t            rem_r, rem_nxt;
  bytes_t               used_r, used_nxt;
  batch_t               gr_r, gr_nxt;
  logic                 succ_r, succ_nxt;

  logic                 out_valid_r, out_valid_nxt;
  batch_t               out_gr_r, out_gr_nxt;
  logic                 out_succ_r, out_succ_nxt;
  bytes_t               out_occ_r, out_occ_nxt;

  alu_word_t            alu_a, alu_b, alu_y;
  logic                 alu_sub;
  batch_t               start;
  logic                 in_acc;

  bbrg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bbrg_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);

  always_comb begin
    if (in_ch.batch < cfg.min_batch) begin
      start = cfg.min_batch;
    end else if (in_ch.batch < cfg.default_batch) begin
      start = in_ch.batch;
    end else begin
      start = cfg.default_batch;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tb_nxt        = tb_r;
    mc_nxt        = mc_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    slack_nxt     = slack_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    used_nxt      = used_r;
    gr_nxt        = gr_r;
    succ_nxt      = succ_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_gr_nxt    = out_gr_r;
    out_succ_nxt  = out_succ_r;
    out_occ_nxt   = out_occ_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_ch.command;
          prod_nxt = '0;
          cnt_nxt  = '1;
          gr_nxt   = '0;
          if (in_ch.command == CMD_ACQUIRE) begin
            succ_nxt = 1'b0;
            tb_nxt   = start;
            mc_nxt   = start;
            if (start < cfg.min_batch) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_MUL;
            end
          end else begin
            succ_nxt = 1'b1;
            mc_nxt   = in_ch.batch;
            if (in_ch.batch == '0) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        alu_a    = {prod_r[ALU_W-2:0], 1'b0};
        alu_b    = mc_r[BATCH_W-1] ? ext_bytes(cfg.activation_bytes) : '0;
        prod_nxt = alu_y;
        mc_nxt   = {mc_r[BATCH_W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = (cmd_r == CMD_RELEASE) ? S_RDIF : S_MAXW;
        end
      end
      S_MAXW: begin
        alu_a     = ext_bytes(used_r);
        alu_b     = ext_bytes(cfg.weight_bytes);
        alu_sub   = 1'b1;
        acc_nxt   = alu_y[ALU_W-1] ? ext_bytes(cfg.weight_bytes) : ext_bytes(used_r);
        state_nxt = S_SLACK;
      end
      S_SLACK: begin
        alu_a     = ext_bytes(cfg.budget_bytes);
        alu_b     = acc_r;
        alu_sub   = 1'b1;
        slack_nxt = alu_y;
        state_nxt = S_QSUM;
      end
      S_QSUM: begin
        alu_a     = ext_bytes(used_r);
        alu_b     = slack_r;
        q_nxt     = alu_y;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        alu_a     = slack_r;
        alu_b     = prod_r;
        alu_sub   = 1'b1;
        rem_nxt   = alu_y;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        alu_a = rem_r;
        alu_b = ext_bytes(cfg.activation_bytes);
        if (!rem_r[ALU_W-1]) begin
          gr_nxt    = tb_r;
          succ_nxt  = 1'b1;
          state_nxt = S_UPD;
        end else if (tb_r == cfg.min_batch) begin
          state_nxt = S_DONE;
        end else begin
          rem_nxt = alu_y;
          tb_nxt  = tb_r - 1'b1;
        end
      end
      S_UPD: begin
        alu_a     = q_r;
        alu_b     = rem_r;
        alu_sub   = 1'b1;
        used_nxt  = alu_y[BYTE_W-1:0];
        state_nxt = S_DONE;
      end
      S_RDIF: begin
        alu_a     = ext_bytes(used_r);
        alu_b     = prod_r;
        alu_sub   = 1'b1;
        rem_nxt   = alu_y;
        state_nxt = S_RCMP;
      end
      S_RCMP: begin
        alu_a     = rem_r;
        alu_b     = ext_bytes(cfg.weight_bytes);
        alu_sub   = 1'b1;
        used_nxt  = alu_y[ALU_W-1] ? cfg.weight_bytes : rem_r[BYTE_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_gr_nxt    = gr_r;
          out_succ_nxt  = succ_r;
          out_occ_nxt   = used_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= WEIGHT_BYTES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tb_r       <= tb_nxt;
    mc_r       <= mc_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    slack_r    <= slack_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    gr_r       <= gr_nxt;
    succ_r     <= succ_nxt;
    out_gr_r   <= out_gr_nxt;
    out_succ_r <= out_succ_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.granted   = out_gr_r;
  assign out_ch.success   = out_succ_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

@@ rtl/bbrg_cfg.sv @@
module bbrg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bbrg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bbrg_pkg::BYTE_W-1:0]    cfg_data,
  output bbrg_pkg::cfg_t                 cfg
);
  import bbrg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_batch        <= MIN_BATCH_RST;
      cfg_r.default_batch    <= DEFAULT_BATCH_RST;
      cfg_r.activation_bytes <= ACT_BYTES_RST;
      cfg_r.weight_bytes     <= WEIGHT_BYTES_RST;
      cfg_r.budget_bytes     <= BUDGET_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_BATCH:     cfg_r.min_batch        <= cfg_data[BATCH_W-1:0];
        REG_DEFAULT_BATCH: cfg_r.default_batch    <= cfg_data[BATCH_W-1:0];
        REG_ACT_BYTES:     cfg_r.activation_bytes <= cfg_data;
        REG_WEIGHT_BYTES:  cfg_r.weight_bytes     <= cfg_data;
        REG_BUDGET_BYTES:  cfg_r.budget_bytes     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bbrg_alu.sv @@
module bbrg_alu (
  input  logic [bbrg_pkg::ALU_W-1:0] a,
  input  logic [bbrg_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [bbrg_pkg::ALU_W-1:0] y
);
  import bbrg_pkg::*;

  alu_word_t b_op;

  always_comb begin
    b_op = sub ? ~b : b;
    y    = a + b_op + {{(ALU_W-1){1'b0}}, sub};
  end

endmodule

@@ dv/tb_batch_budget_reservation_guard.sv @@
`timescale 1ns / 100ps

module tb_batch_budget_reservation_guard;
  import bbrg_pkg::*;

  localparam int     CYCLE_LIMIT   = 4_000_000;
  localparam int     HOLD_OFF_LEN  = 800;
  localparam int     SETTLE_CYCLES = 300;
  localparam bytes_t BYTES_MAX     = '1;

  typedef struct packed {
    logic   command;
    batch_t batch;
  } guard_cmd_t;

  typedef struct packed {
    batch_t granted;
    logic   success;
    bytes_t occupancy;
  } guard_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  bytes_t               cfg_data;

  bbrg_in_if  in_ch ();
  bbrg_out_if out_ch ();

  batch_budget_reservation_guard dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  guard_cmd_t    pending_requests[$];
  guard_result_t awaited_outcomes[$];
  cfg_t          guard_cfg;
  bytes_t        held_bytes      = WEIGHT_BYTES_RST;
  int            requests_issued = 0;
  int            outcomes_seen   = 0;
  int            bad_outcomes    = 0;
  int            cycle_count     = 0;
  int            hold_left       = 0;
  bit            hold_off_armed  = 0;
  bit            hold_off_done   = 0;
  bit            steady          = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic guard_result_t reserve_or_release(input logic cmd, input batch_t req);
    guard_result_t r;
    int            start;
    int            tb;
    logic [63:0]   act;
    logic [63:0]   total;
    logic [63:0]   occ;
    r.granted = '0;
    r.success = 1'b0;
    if (cmd == CMD_ACQUIRE) begin
      if (req < guard_cfg.min_batch) start = int'(guard_cfg.min_batch);
      else if (req < guard_cfg.default_batch) start = int'(req);
      else start = int'(guard_cfg.default_batch);
      for (tb = start; tb >= int'(guard_cfg.min_batch) && !r.success; tb--) begin
        act   = 64'(guard_cfg.activation_bytes) * 64'(tb);
        total = 64'(guard_cfg.weight_bytes) + act;
        occ   = 64'(held_bytes) + act;
        if (total <= 64'(guard_cfg.budget_bytes) && occ <= 64'(guard_cfg.budget_bytes)) begin
          held_bytes = occ[BYTE_W-1:0];
          r.granted  = batch_t'(tb);
          r.success  = 1'b1;
        end
      end
    end else begin
      r.success = 1'b1;
      if (req != '0) begin
        act   = 64'(guard_cfg.activation_bytes) * 64'(req);
        total = 64'(guard_cfg.weight_bytes) + act;
        if (64'(held_bytes) >= total) held_bytes = held_bytes - act[BYTE_W-1:0];
        else held_bytes = guard_cfg.weight_bytes;
      end
    end
    r.occupancy = held_bytes;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    bad_outcomes++;
    if (bad_outcomes <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : drive_requests
    guard_cmd_t nxt;
    logic       offer_now;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= CMD_ACQUIRE;
      in_ch.batch   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_outcomes.push_back(reserve_or_release(in_ch.command, in_ch.batch));
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer_now = (pending_requests.size() != 0) && (steady || $urandom_range(0, 99) >= 32);
        if (offer_now) begin
          nxt = pending_requests.pop_front();
          requests_issued++;
          in_ch.valid   <= 1'b1;
          in_ch.command <= nxt.command;
          in_ch.batch   <= nxt.batch;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_outcomes
    guard_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        outcomes_seen++;
        if (awaited_outcomes.size() == 0) begin
          note_failure($sformatf("unexpected beat granted=%0d success=%0d occupancy=%0d",
                                 out_ch.granted, out_ch.success, out_ch.occupancy));
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_ch.granted !== want.granted || out_ch.success !== want.success ||
              out_ch.occupancy !== want.occupancy) begin
            note_failure($sformatf({"mismatch: expected granted=%0d success=%0d ",
                                    "occupancy=%0d, got granted=%0d success=%0d occupancy=%0d"},
                                   want.granted, want.success, want.occupancy,
                                   out_ch.granted, out_ch.success, out_ch.occupancy));
          end
        end
      end
      if (hold_off_armed && !hold_off_done) begin
        hold_left     = HOLD_OFF_LEN;
        hold_off_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic offer(input logic cmd, input batch_t b);
    guard_cmd_t c;
    c.command = cmd;
    c.batch   = b;
    pending_requests.push_back(c);
  endtask

  task automatic wait_until_settled();
    while (pending_requests.size() != 0 || outcomes_seen < requests_issued) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bytes_t value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_MIN_BATCH:     guard_cfg.min_batch        = value[BATCH_W-1:0];
      REG_DEFAULT_BATCH: guard_cfg.default_batch    = value[BATCH_W-1:0];
      REG_ACT_BYTES:     guard_cfg.activation_bytes = value;
      REG_WEIGHT_BYTES:  guard_cfg.weight_bytes     = value;
      REG_BUDGET_BYTES:  guard_cfg.budget_bytes     = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input batch_t mn, input batch_t df, input bytes_t act,
                            input bytes_t wt, input bytes_t bud);
    write_reg(REG_MIN_BATCH, bytes_t'(mn));
    write_reg(REG_DEFAULT_BATCH, bytes_t'(df));
    write_reg(REG_ACT_BYTES, act);
    write_reg(REG_WEIGHT_BYTES, wt);
    write_reg(REG_BUDGET_BYTES, bud);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bytes_t rand_bytes();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[BYTE_W-1:0];
  endfunction

  task automatic random_setup();
    batch_t      mn;
    batch_t      df;
    logic [63:0] act;
    logic [63:0] wt;
    logic [63:0] bud;
    case ($urandom_range(0, 9))
      0: mn = 8'd0;
      1: mn = 8'd255;
      2: mn = batch_t'($urandom_range(0, 255));
      default: mn = batch_t'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 7))
      0: df = 8'd255;
      1: df = batch_t'($urandom_range(1, 255));
      default: df = batch_t'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 7))
      0: act = 64'd0;
      1: act = 64'(BYTES_MAX);
      2: act = 64'(rand_bytes());
      default: act = 64'($urandom_range(1, 1 << 24));
    endcase
    case ($urandom_range(0, 5))
      0: wt = 64'd0;
      1: wt = 64'(rand_bytes());
      default: wt = 64'($urandom_range(0, 1 << 28));
    endcase
    case ($urandom_range(0, 7))
      0: bud = 64'd0;
      1: bud = 64'(BYTES_MAX);
      2: bud = 64'(rand_bytes());
      default: bud = wt + act * 64'($urandom_range(0, df + 2)) + 64'(rand_bytes()) % (act + 1);
    endcase
    if (bud > 64'(BYTES_MAX)) bud = 64'(BYTES_MAX);
    set_config(mn, df, act[BYTE_W-1:0], wt[BYTE_W-1:0], bud[BYTE_W-1:0]);
  endtask

  task automatic fill_random(input int count);
    int     n;
    int     top;
    batch_t b;
    n = 0;
    while (n < count) begin
      case ($urandom_range(0, 9))
        7: begin
          offer(CMD_RELEASE, batch_t'($urandom_range(0, 255)));
          n++;
        end
        8: begin
          offer(CMD_ACQUIRE, batch_t'($urandom_range(0, 255)));
          n++;
        end
        default: begin
          top = int'(guard_cfg.default_batch) + 2;
          if (top > 255) top = 255;
          b = batch_t'($urandom_range(0, top));
          offer(CMD_ACQUIRE, b);
          n++;
          if ($urandom_range(0, 2) != 0) begin
            offer(CMD_RELEASE, b);
            n++;
          end
        end
      endcase
    end
  endtask

  initial begin
    guard_cfg.min_batch        = MIN_BATCH_RST;
    guard_cfg.default_batch    = DEFAULT_BATCH_RST;
    guard_cfg.activation_bytes = ACT_BYTES_RST;
    guard_cfg.weight_bytes     = WEIGHT_BYTES_RST;
    guard_cfg.budget_bytes     = BUDGET_BYTES_RST;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: fill to budget, overflow, release past the floor
    offer(CMD_ACQUIRE, 8'd8);
    offer(CMD_ACQUIRE, 8'd255);
    offer(CMD_ACQUIRE, 8'd0);
    offer(CMD_RELEASE, 8'd255);
    offer(CMD_RELEASE, 8'd0);
    offer(CMD_ACQUIRE, 8'd3);
    offer(CMD_RELEASE, 8'd1);
    wait_until_settled();

    // zero minimum batch, widest byte values
    set_config(8'd0, 8'd255, BYTES_MAX, '0, BYTES_MAX);
    offer(CMD_RELEASE, 8'd255);
    offer(CMD_ACQUIRE, 8'd0);
    offer(CMD_ACQUIRE, 8'd1);
    offer(CMD_ACQUIRE, 8'd255);
    offer(CMD_RELEASE, 8'd1);
    wait_until_settled();

    // minimum above default clamp
    set_config(8'd200, 8'd5, 36'd1, 36'd0, 36'd1000);
    offer(CMD_ACQUIRE, 8'd100);
    offer(CMD_ACQUIRE, 8'd250);
    offer(CMD_ACQUIRE, 8'd0);
    wait_until_settled();

    // weight raised after grants: release lifts occupancy to the floor
    set_config(8'd1, 8'd8, 36'd1000, 36'd50000, 36'd100000);
    offer(CMD_RELEASE, 8'd1);
    offer(CMD_ACQUIRE, 8'd255);
    offer(CMD_RELEASE, 8'd8);
    wait_until_settled();

    // budget below weight: nothing fits
    set_config(8'd1, 8'd8, 36'd1, 36'd2000, 36'd1000);
    offer(CMD_ACQUIRE, 8'd4);
    offer(CMD_ACQUIRE, 8'd0);
    wait_until_settled();

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        set_config(MIN_BATCH_RST, DEFAULT_BATCH_RST, ACT_BYTES_RST, WEIGHT_BYTES_RST,
                   BUDGET_BYTES_RST);
        hold_off_armed = 1'b1;
      end else begin
        random_setup();
      end
      steady = (phase == 3);
      fill_random(200);
      wait_until_settled();
    end
    steady = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_outcomes.size()));
    if (bad_outcomes == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bbrg_pkg.sv
rtl/bbrg_in_if.sv
rtl/bbrg_out_if.sv
rtl/bbrg_cfg.sv
rtl/bbrg_alu.sv
rtl/batch_budget_reservation_guard.sv
dv/tb_batch_budget_reservation_guard.sv
